[rtl/core/swaf_pkg.sv]
// ============================================================================
// swaf_pkg: shared types and constants for the sparse weighted-average filter
// Request/response payload structs, command and status codes, sizes.
// ============================================================================
package swaf_pkg;

   localparam int MAX_ELEMENTS = 4096;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int LIMIT_W      = 13;
   localparam int NUM_W        = 48;
   localparam int WSUM_W       = 32;
   localparam int DENS_W       = 16;
   localparam int QUOT_W       = 17;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_APPLY = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam logic [15:0] ONE_Q15 = 16'h8000;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] row_index;
      logic [15:0] col_index;
      logic [15:0] density_value;
      logic [15:0] weight;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] filtered_density;
      logic        row_empty;
   } rsp_type;

   // classified operation passed from front to back
   typedef struct packed {
      logic              skip;
      logic [1:0]        command;
      logic [ADDR_W-1:0] row;
      logic [ADDR_W-1:0] col;
      logic [15:0]       density;
      logic [15:0]       weight;
   } op_type;

endpackage

[rtl/core/sparse_weighted_average_filter_unit.sv]
// ============================================================================
// sparse_weighted_average_filter_unit: sparse weighted-average density filter
// Loads densities, accumulates weighted triplets per row, returns averages.
// ============================================================================
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//  csr     | in        | csr_wr_en          | csr_wr_data (13 bit)
//
// Load, apply and skipped requests pass through fetch, execute and respond in
// the back end; reads with nonzero weight sum also pass through the divider.
// The single accumulator RAM port pair sets the rate of one request at a time.
// After reset the back end clears all 4096 accumulator rows while requests
// queue (up to 4) and then stall.
// A stalled response holds the back end; the front queue fills until it stalls.
module sparse_weighted_average_filter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swaf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swaf_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [12:0]       csr_wr_data
);
   import swaf_pkg::*;

   logic [12:0] limit_ff;
   logic        op_valid, op_take;
   op_type      op_data;

   // element limit register
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 13'(MAX_ELEMENTS);
      else if (csr_wr_en) limit_ff <= csr_wr_data;
   end

   swaf_front u_front (.clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .req_data(req_data), .limit(limit_ff),
      .op_valid(op_valid), .op_data(op_data), .op_take(op_take));

   swaf_back u_back (.clock(clock), .reset(reset), .op_valid(op_valid),
      .op_data(op_data), .op_take(op_take), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_data(rsp_data));
endmodule

[rtl/core/swaf_ram.sv]
// ============================================================================
// swaf_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ============================================================================
module swaf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // storage with registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

[rtl/core/swaf_front.sv]
// ============================================================================
// swaf_front: request intake and classification
// Range-checks indices, clamps density, and queues ops for the back end.
// ============================================================================
module swaf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  swaf_pkg::req_type     req_data,
   input  logic [12:0]           limit,
   output logic                  op_valid,
   output swaf_pkg::op_type      op_data,
   input  logic                  op_take
);
   import swaf_pkg::*;

   localparam int QD = 4;
   op_type          q_ff [QD];
   logic [1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [16:0]     lim;
   logic            row_ok, col_ok, push, pop;
   op_type          op_new;

   // effective limit is min(num_elements, MAX_ELEMENTS)
   assign lim    = ({4'd0, limit} > 17'(MAX_ELEMENTS)) ? 17'(MAX_ELEMENTS)
                                                        : {4'd0, limit};
   assign row_ok = (req_data.row_index != 16'd0) && ({1'b0, req_data.row_index} <= lim);
   assign col_ok = (req_data.col_index != 16'd0) && ({1'b0, req_data.col_index} <= lim);

   always_comb begin
      op_new         = '0;
      op_new.command = req_data.command;
      op_new.row     = ADDR_W'(req_data.row_index - 16'd1);
      op_new.col     = ADDR_W'(req_data.col_index - 16'd1);
      op_new.weight  = req_data.weight;
      op_new.density = (req_data.density_value > ONE_Q15) ? ONE_Q15 : req_data.density_value;
      case (req_data.command)
         CMD_LOAD, CMD_READ: op_new.skip = !row_ok;
         CMD_APPLY:          op_new.skip = !(row_ok && col_ok);
         default:            op_new.skip = 1'b1;
      endcase
   end

   assign req_stall = (cnt_ff == 3'(QD));
   assign push      = req_valid && !req_stall;
   assign op_valid  = (cnt_ff != 3'd0);
   assign op_data   = q_ff[rp_ff];
   assign pop       = op_valid && op_take;

   assign wp_in  = push ? wp_ff + 2'd1 : wp_ff;
   assign rp_in  = pop  ? rp_ff + 2'd1 : rp_ff;
   assign cnt_in = cnt_ff + 3'(push) - 3'(pop);

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= op_new;
   end
endmodule

[rtl/core/swaf_div.sv]
// ============================================================================
// swaf_div: restoring divider, one quotient bit per cycle
// Computes floor(num / den); quotient beyond 17 bits is clamped to all ones.
// ============================================================================
module swaf_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [48:0]  num,
   input  logic [31:0]  den,
   output logic         done,
   output logic [16:0]  quot
);
   import swaf_pkg::*;

   logic [48:0] n_ff, n_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [16:0] q_ff, q_in;
   logic        big_ff;
   logic [5:0]  i_ff, i_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;

   // shift in one dividend bit, subtract when it fits
   assign trial = {r_ff, n_ff[48]} - {2'b0, d_ff};

   always_comb begin
      n_in = n_ff; r_in = r_ff; q_in = q_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (busy_ff) begin
         n_in = {n_ff[47:0], 1'b0};
         if (!trial[33]) begin
            r_in = trial[32:0];
            q_in = {q_ff[15:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], n_ff[48]};
            q_in = {q_ff[15:0], 1'b0};
         end
         i_in = i_ff - 6'd1;
         if (i_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // quotient exceeds 17 bits when num >> 17 >= den
   always_ff @(posedge clock) begin
      if (start) begin
         big_ff <= ({17'd0, num[48:17]} >= {17'd0, den}) ? 1'b1 : 1'b0;
         n_ff   <= {num[16:0], 32'd0};
         r_ff   <= {1'b0, num[48:17]};
         d_ff   <= den;
         q_ff   <= '0;
      end else begin
         n_ff <= n_in;
         r_ff <= r_in;
         q_ff <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         i_ff    <= 6'd16;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
   end

   assign done = done_ff;
   assign quot = big_ff ? '1 : q_ff;
endmodule

[rtl/core/swaf_back.sv]
// ============================================================================
// swaf_back: executes queued ops against the element stores
// Clears accumulators after reset, does read-modify-write, divides for reads.
// ============================================================================
module swaf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  swaf_pkg::op_type      op_data,
   output logic                  op_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output swaf_pkg::rsp_type     rsp_data
);
   import swaf_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]        st_ff, st_in;
   logic [ADDR_W:0]   clr_ff, clr_in;
   op_type            op_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              out_v_ff;

   logic              d_we, a_we;
   logic [ADDR_W-1:0] a_wa, a_ra, d_ra;
   logic [DENS_W-1:0] d_rd;
   logic [NUM_W+WSUM_W-1:0] a_wd, a_rd;

   logic [31:0]       prod_ff;
   logic [48:0]       nsum;
   logic [32:0]       wsum;
   logic              start;
   logic              done;
   logic [16:0]       quot;
   logic [48:0]       dnum;

   // density store and combined accumulator store
   swaf_ram #(.WIDTH(DENS_W), .DEPTH(MAX_ELEMENTS)) u_dens (
      .clock(clock), .wr_en(d_we), .wr_addr(op_ff.row), .wr_data(op_ff.density),
      .rd_addr(d_ra), .rd_data(d_rd));
   swaf_ram #(.WIDTH(NUM_W+WSUM_W), .DEPTH(MAX_ELEMENTS)) u_acc (
      .clock(clock), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
      .rd_addr(a_ra), .rd_data(a_rd));

   // read the incoming op while idle, then keep reading the held op
   assign d_ra    = (st_ff == S_IDLE) ? op_data.col : op_ff.col;
   assign a_ra    = (st_ff == S_IDLE) ? op_data.row : op_ff.row;
   assign op_take = (st_ff == S_IDLE) && op_valid;

   assign nsum  = {1'b0, a_rd[NUM_W+WSUM_W-1:WSUM_W]} + 49'(prod_ff);
   assign wsum  = {1'b0, a_rd[WSUM_W-1:0]} + 33'(op_ff.weight);
   assign dnum  = {1'b0, a_rd[NUM_W+WSUM_W-1:WSUM_W]} + 49'(a_rd[WSUM_W-1:1]);
   assign start = (st_ff == S_EXEC) && !op_ff.skip && (op_ff.command == CMD_READ)
                  && (a_rd[WSUM_W-1:0] != '0);

   // divider kept registered on operands via its own start capture
   swaf_div u_div (.clock(clock), .reset(reset), .start(start), .num(dnum),
      .den(a_rd[WSUM_W-1:0]), .done(done), .quot(quot));

   // write port selection
   always_comb begin
      d_we = 1'b0; a_we = 1'b0; a_wa = op_ff.row; a_wd = '0;
      if (st_ff == S_CLEAR) begin
         a_we = 1'b1;
         a_wa = clr_ff[ADDR_W-1:0];
      end else if (st_ff == S_EXEC && !op_ff.skip) begin
         case (op_ff.command)
            CMD_LOAD:  d_we = 1'b1;
            CMD_APPLY: begin
               a_we = 1'b1;
               a_wd = {nsum[48] ? {NUM_W{1'b1}} : nsum[NUM_W-1:0],
                       wsum[32] ? {WSUM_W{1'b1}} : wsum[WSUM_W-1:0]};
            end
            CMD_READ:  a_we = 1'b1;
            default:   a_we = 1'b0;
         endcase
      end
   end

   // sequencer
   always_comb begin
      st_in  = st_ff;
      clr_in = clr_ff;
      rsp_in = rsp_ff;
      case (st_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (ADDR_W+1)'(MAX_ELEMENTS-1)) st_in = S_IDLE;
         end
         S_IDLE:  if (op_valid) st_in = S_FETCH;
         S_FETCH: st_in = S_EXEC;
         S_EXEC: begin
            rsp_in = '0;
            st_in  = S_OUT;
            if (op_ff.skip) rsp_in.status = ST_SKIP;
            else if (op_ff.command == CMD_APPLY) begin
               if (nsum[48] || wsum[32]) rsp_in.status = ST_SAT;
            end else if (op_ff.command == CMD_READ) begin
               if (a_rd[WSUM_W-1:0] == '0) rsp_in.row_empty = 1'b1;
               else st_in = S_DIV;
            end
         end
         S_DIV: if (done) begin
            rsp_in.filtered_density = (quot > 17'(ONE_Q15)) ? ONE_Q15 : quot[15:0];
            st_in = S_OUT;
         end
         S_OUT:   if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         clr_ff   <= clr_in;
      end
   end

   // payload registers and product stage
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (op_take) op_ff <= op_data;
      if (st_ff == S_FETCH) prod_ff <= 32'(op_ff.weight) * 32'(d_rd);
   end

   assign out_v_ff  = (st_ff == S_OUT);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;
endmodule

[rtl/core/swaf_checker.sv]
// ============================================================================
// swaf_checker: port-level checks for the filter unit
// Watches response codes and handshake behavior.
// ============================================================================
module swaf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input swaf_pkg::rsp_type rsp_data
);
   import swaf_pkg::*;

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped under stall");

   // empty row carries zero average
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_empty |-> rsp_data.filtered_density == 16'd0)
      else $error("empty row with nonzero average");

   // average never exceeds one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.filtered_density <= ONE_Q15)
      else $error("average above one");

   // status code valid and non-ok results carry no average
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.filtered_density == 16'd0 && !rsp_data.row_empty
         && (rsp_data.status == ST_SKIP || rsp_data.status == ST_SAT))
      else $error("bad status result");
endmodule

bind sparse_weighted_average_filter_unit swaf_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_data(rsp_data));

[tb/swaf_filter_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// swaf_filter_checker: response checker for the sparse weighted-average filter
// Watches the request, response and csr ports, keeps its own density and
// accumulator stores, predicts each response and compares it in order.
// ============================================================================
module swaf_filter_checker
   import swaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output int          fail_count,
   output int          awaited_count,
   output int          checked_count
);

   logic [15:0]       density_mem [MAX_ELEMENTS];
   logic [NUM_W-1:0]  numer_mem   [MAX_ELEMENTS];
   logic [WSUM_W-1:0] wsum_mem    [MAX_ELEMENTS];
   logic [12:0]       elem_count;
   rsp_type           awaited_rsp [$];

   initial begin
      fail_count    = 0;
      awaited_count = 0;
      checked_count = 0;
      elem_count    = 13'd4096;
   end

   // 1-based index check against the active element count
   function automatic bit slot_ok(input logic [15:0] idx, output int slot);
      int lim;
      lim  = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
      slot = int'(idx) - 1;
      return (idx >= 1) && (int'(idx) <= lim);
   endfunction

   // update the predicted stores for one request and return its response
   function automatic rsp_type predict_filter_result(input req_type r);
      rsp_type     o;
      int          rs, cs;
      logic [63:0] acc, ws, quo;
      o = '0;
      case (r.command)
         CMD_LOAD: begin
            if (slot_ok(r.row_index, rs))
               density_mem[rs] = (r.density_value > ONE_Q15) ? ONE_Q15 : r.density_value;
            else
               o.status = ST_SKIP;
         end
         CMD_APPLY: begin
            if (slot_ok(r.row_index, rs) && slot_ok(r.col_index, cs)) begin
               acc = 64'(numer_mem[rs]) + 64'(r.weight) * 64'(density_mem[cs]);
               ws  = 64'(wsum_mem[rs]) + 64'(r.weight);
               if (acc > 64'hFFFF_FFFF_FFFF) begin
                  acc      = 64'hFFFF_FFFF_FFFF;
                  o.status = ST_SAT;
               end
               if (ws > 64'hFFFF_FFFF) begin
                  ws       = 64'hFFFF_FFFF;
                  o.status = ST_SAT;
               end
               numer_mem[rs] = acc[NUM_W-1:0];
               wsum_mem[rs]  = ws[WSUM_W-1:0];
            end else begin
               o.status = ST_SKIP;
            end
         end
         CMD_READ: begin
            if (slot_ok(r.row_index, rs)) begin
               ws = 64'(wsum_mem[rs]);
               if (ws == 0) begin
                  o.row_empty = 1'b1;
               end else begin
                  quo = (64'(numer_mem[rs]) + (ws >> 1)) / ws;
                  o.filtered_density = (quo > 64'(ONE_Q15)) ? ONE_Q15 : quo[15:0];
               end
               numer_mem[rs] = '0;
               wsum_mem[rs]  = '0;
            end else begin
               o.status = ST_SKIP;
            end
         end
         default: o.status = ST_SKIP;
      endcase
      return o;
   endfunction

   // predict on accepted requests, compare accepted responses in order
   always @(posedge clock) begin : monitor
      int      i;
      rsp_type exp_r;
      if (reset) begin
         for (i = 0; i < MAX_ELEMENTS; i++) begin
            numer_mem[i] = '0;
            wsum_mem[i]  = '0;
         end
         elem_count = 13'd4096;
         awaited_rsp.delete();
      end else begin
         if (csr_wr_en)
            elem_count = csr_wr_data;
         if (req_valid && !req_stall)
            awaited_rsp.push_back(predict_filter_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected response status %0d filt %0d empty %0d", $time,
                        rsp_data.status, rsp_data.filtered_density, rsp_data.row_empty);
               fail_count++;
            end else begin
               exp_r = awaited_rsp.pop_front();
               if (rsp_data !== exp_r) begin
                  $display("%0t: mismatch exp status %0d filt %0d empty %0d, got %0d %0d %0d",
                           $time, exp_r.status, exp_r.filtered_density, exp_r.row_empty,
                           rsp_data.status, rsp_data.filtered_density, rsp_data.row_empty);
                  fail_count++;
               end
               checked_count++;
            end
         end
      end
      awaited_count = awaited_rsp.size();
   end

endmodule

[tb/tb_sparse_weighted_average_filter_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_sparse_weighted_average_filter_unit: stimulus for the filter unit
// Directed corner requests, a short full-weight pass on one row, then random
// load/apply/read streams over several element counts with random idling.
// ============================================================================
module tb_sparse_weighted_average_filter_unit;
   import swaf_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;

   int          fail_count, awaited_count, checked_count;
   int          sent_count;
   bit          idling;
   bit          loaded [1:MAX_ELEMENTS];
   int          active_limit;

   sparse_weighted_average_filter_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   swaf_filter_checker filter_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .awaited_count(awaited_count),
      .checked_count(checked_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run limit
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   // response stall in random bursts
   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 11);
         end
         rsp_stall <= (hold > 0);
      end
   end

   // drive one request, with an optional idle burst ahead of it
   task automatic send_request(input req_type r);
      int gap;
      @(negedge clock);
      if (idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [15:0] row, col, dens, w);
      req_type r;
      r.command = cmd;
      r.row_index = row;
      r.col_index = col;
      r.density_value = dens;
      r.weight = w;
      if (cmd == CMD_LOAD && row >= 1 && row <= active_limit)
         loaded[row] = 1'b1;
      send_request(r);
   endtask

   // hold off until every response is in, then let the back end settle
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_limit(input logic [12:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      active_limit = (value > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(value);
   endtask

   // one random request: mostly well-formed traffic, some noise
   task automatic random_request();
      int          kind, tries;
      logic [15:0] row, col;
      logic [1:0]  cmd;
      kind = $urandom_range(0, 99);
      if (active_limit == 0)
         kind = 99;
      row = 16'($urandom_range(1, (active_limit > 0) ? active_limit : 1));
      if (kind < 20) begin
         send_fields(CMD_LOAD, row, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (kind < 70) begin
         col = 0;
         for (tries = 0; tries < 8 && col == 0; tries++) begin
            col = 16'($urandom_range(1, active_limit));
            if (!loaded[col])
               col = 0;
         end
         if (col == 0)
            send_fields(CMD_LOAD, row, 16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_fields(CMD_APPLY, row, col, 16'($urandom), 16'($urandom));
      end else if (kind < 85) begin
         send_fields(CMD_READ, row, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         cmd = 2'($urandom);
         row = 16'($urandom);
         col = 16'($urandom);
         // never touch a density that was not loaded
         if (col >= 1 && col <= active_limit && col <= MAX_ELEMENTS && !loaded[col])
            col = 0;
         send_fields(cmd, row, col, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin : stimulus
      int          p, n, i;
      logic [12:0] limits [7];
      int          counts [7];
      limits = '{13'd16, 13'd1, 13'd0, 13'd8191, 13'd200, 13'd4096, 13'd3};
      counts = '{250, 60, 30, 220, 250, 250, 190};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idling = 1'b1;
      sent_count = 0;
      active_limit = MAX_ELEMENTS;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      write_limit(13'd4096);

      // directed corners: clamp, bounds, zero and full weights, empty rows
      send_fields(CMD_LOAD, 16'd1, 16'd0, ONE_Q15, 16'd0);
      send_fields(CMD_LOAD, 16'd2, 16'd0, 16'hFFFF, 16'd0);
      send_fields(CMD_LOAD, 16'd3, 16'd0, 16'd0, 16'd0);
      send_fields(CMD_LOAD, 16'd4096, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      send_fields(CMD_LOAD, 16'd0, 16'd0, 16'd100, 16'd0);
      send_fields(CMD_LOAD, 16'd4097, 16'd0, 16'd100, 16'd0);
      send_fields(CMD_LOAD, 16'hFFFF, 16'd0, 16'd100, 16'd0);
      send_fields(CMD_APPLY, 16'd1, 16'd1, 16'd0, 16'hFFFF);
      send_fields(CMD_APPLY, 16'd1, 16'd2, 16'd0, 16'd0);
      send_fields(CMD_APPLY, 16'd1, 16'd3, 16'd0, 16'd1);
      send_fields(CMD_APPLY, 16'd4096, 16'd4096, 16'd0, 16'h5555);
      send_fields(CMD_APPLY, 16'd0, 16'd1, 16'd0, 16'd7);
      send_fields(CMD_APPLY, 16'd1, 16'hFFFF, 16'd0, 16'd7);
      send_fields(CMD_APPLY, 16'd2, 16'd0, 16'd0, 16'd7);
      send_fields(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fields(CMD_READ, 16'd1, 16'd0, 16'd0, 16'd0);
      send_fields(CMD_READ, 16'd4096, 16'd0, 16'd0, 16'd0);
      send_fields(CMD_READ, 16'd5, 16'd0, 16'd0, 16'd0);
      send_fields(CMD_READ, 16'd0, 16'd0, 16'd0, 16'd0);
      send_fields(CMD_READ, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      send_fields(CMD_READ, 16'd1, 16'd0, 16'd0, 16'd0);
      drain_requests();

      // back-to-back full-weight applies on one row, then read it back
      idling = 1'b0;
      for (i = 0; i < 40; i++)
         send_fields(CMD_APPLY, 16'd7, 16'd1, 16'd0, 16'hFFFF);
      send_fields(CMD_READ, 16'd7, 16'd0, 16'd0, 16'd0);
      drain_requests();
      idling = 1'b1;

      // random phases over several element counts; last one without idling
      for (p = 0; p < 7; p++) begin
         write_limit(limits[p]);
         if (p == 6)
            idling = 1'b0;
         for (n = 0; n < counts[p]; n++)
            random_request();
         drain_requests();
      end

      // final wait for stragglers
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d requests, %0d responses checked", sent_count, checked_count);
      $display("element counts 4096, 16, 1, 0, 8191, 200, 3 plus a full-weight row run");
      if (fail_count == 0 && awaited_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
